>>> hdl/ssrc_pkg.sv
// shared types and constants for the stepper speed ramp with centering
package ssrc_pkg;

   localparam int TARGET_W    = 11;
   localparam int SENSE_W     = 10;
   localparam int PERIOD_W    = 16;
   localparam int LEVEL_OUT_W = 11;
   localparam int ERR_W       = SENSE_W + 1;

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 10;

   localparam int LEVEL_COUNT_DEF = 2000;

   localparam int RATE_BASE   = 300;
   localparam int RATE_SHIFT  = 2;
   localparam int STOP_PERIOD = 2500;

   localparam int DIVIDEND    = 1500000;
   localparam int DIVIDEND_W  = 21;

   localparam logic [SENSE_W-1:0] LEFT_REF_RST    = SENSE_W'(500);
   localparam logic [SENSE_W-1:0] RIGHT_REF_RST   = SENSE_W'(500);
   localparam logic [SENSE_W-1:0] LEFT_LIMIT_RST  = SENSE_W'(150);
   localparam logic [SENSE_W-1:0] RIGHT_LIMIT_RST = SENSE_W'(180);

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_EN   = 3'd0,
      CSR_LEFT_REF    = 3'd1,
      CSR_RIGHT_REF   = 3'd2,
      CSR_LEFT_LIMIT  = 3'd3,
      CSR_RIGHT_LIMIT = 3'd4
   } csr_index_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic level_upd;
      logic stop_load;
      logic div_start;
      logic div_right;
      logic store_left;
      logic store_right;
      logic load_out;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic step_work;
      logic step_stop;
      logic div_done;
   } ctrl_stat_type;

endpackage

>>> hdl/ssrc_div.sv
// restoring divider, constant dividend over a variable divisor, one bit a cycle
module ssrc_div #(
   parameter int DIVISOR_W = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [DIVISOR_W-1:0]          divisor,
   output logic                          done,
   output logic [ssrc_pkg::PERIOD_W-1:0] quotient
);

   localparam int QW    = ssrc_pkg::DIVIDEND_W;
   localparam int CNT_W = $clog2(QW);

   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [QW-1:0]        quo_ff, quo_in;
   logic [DIVISOR_W-1:0] dvs_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIVISOR_W:0]   trial;
   logic                 fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[QW-1]};
      fits   = trial >= {1'b0, dvs_ff};
      rem_in = fits ? DIVISOR_W'(trial - {1'b0, dvs_ff}) : trial[DIVISOR_W-1:0];
      quo_in = {quo_ff[QW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= QW'(ssrc_pkg::DIVIDEND);
         dvs_ff <= divisor;
         cnt_ff <= CNT_W'(QW - 1);
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // saturate to the period range
   assign done     = done_ff;
   assign quotient = (|quo_ff[QW-1:ssrc_pkg::PERIOD_W]) ? '1 :
                     quo_ff[ssrc_pkg::PERIOD_W-1:0];

endmodule

>>> hdl/ssrc_datapath.sv
// datapath: config registers, level ramp, centering errors, period and result registers
module ssrc_datapath #(
   parameter int LEVEL_COUNT = ssrc_pkg::LEVEL_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ssrc_pkg::ctrl_cmd_type           cmd,
   output ssrc_pkg::ctrl_stat_type          stat,
   input  logic                             csr_wr,
   input  logic [ssrc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ssrc_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic [ssrc_pkg::TARGET_W-1:0]    req_target_level,
   input  logic                             req_step_seen,
   input  logic [ssrc_pkg::SENSE_W-1:0]     req_left_sense,
   input  logic [ssrc_pkg::SENSE_W-1:0]     req_right_sense,
   output logic [ssrc_pkg::PERIOD_W-1:0]    rsp_left_period,
   output logic [ssrc_pkg::PERIOD_W-1:0]    rsp_right_period,
   output logic                             rsp_run_enable,
   output logic [ssrc_pkg::LEVEL_OUT_W-1:0] rsp_level_now
);

   localparam int TW       = ssrc_pkg::TARGET_W;
   localparam int SW       = ssrc_pkg::SENSE_W;
   localparam int EW       = ssrc_pkg::ERR_W;
   localparam int PW       = ssrc_pkg::PERIOD_W;
   localparam int LEVEL_W  = $clog2(LEVEL_COUNT);
   localparam int CMP_W    = (LEVEL_W > TW) ? LEVEL_W : TW;
   localparam int RATE_MAX = ssrc_pkg::RATE_BASE + (LEVEL_COUNT - 1) * (1 << ssrc_pkg::RATE_SHIFT);
   localparam int SUM_W    = $clog2(RATE_MAX + (1 << SW)) + 1;
   localparam int DIV_W    = SUM_W - 1;

   // configuration
   logic          center_en_ff;
   logic [SW-1:0] left_ref_ff, right_ref_ff, left_limit_ff, right_limit_ff;

   // latched beat
   logic [TW-1:0] target_ff;
   logic          step_ff;
   logic [SW-1:0] lsen_ff, rsen_ff;

   // state
   logic [LEVEL_W-1:0] level_ff;
   logic [PW-1:0]      left_period_ff, right_period_ff;
   logic signed [EW-1:0] err_l_ff, err_r_ff;

   // results
   logic [PW-1:0]      out_left_ff, out_right_ff;
   logic               out_run_ff;
   logic [LEVEL_W-1:0] out_level_ff;

   logic [CMP_W-1:0]     tgt_x, lvl_x, lvl_in;
   logic signed [EW-1:0] err_l_raw, err_r_raw, err_l_in, err_r_in;
   logic                 wall;
   logic signed [SUM_W-1:0] rate, err_sel, sum;
   logic [DIV_W-1:0]     divisor;
   logic                 div_done;
   logic [PW-1:0]        quotient;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_en_ff   <= 1'b0;
         left_ref_ff    <= ssrc_pkg::LEFT_REF_RST;
         right_ref_ff   <= ssrc_pkg::RIGHT_REF_RST;
         left_limit_ff  <= ssrc_pkg::LEFT_LIMIT_RST;
         right_limit_ff <= ssrc_pkg::RIGHT_LIMIT_RST;
      end else if (csr_wr) begin
         unique case (csr_index)
            ssrc_pkg::CSR_CENTER_EN:   center_en_ff   <= csr_data[0];
            ssrc_pkg::CSR_LEFT_REF:    left_ref_ff    <= csr_data[SW-1:0];
            ssrc_pkg::CSR_RIGHT_REF:   right_ref_ff   <= csr_data[SW-1:0];
            ssrc_pkg::CSR_LEFT_LIMIT:  left_limit_ff  <= csr_data[SW-1:0];
            ssrc_pkg::CSR_RIGHT_LIMIT: right_limit_ff <= csr_data[SW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         target_ff <= req_target_level;
         step_ff   <= req_step_seen;
         lsen_ff   <= req_left_sense;
         rsen_ff   <= req_right_sense;
      end
   end

   assign stat.step_work = step_ff && (target_ff != '0);
   assign stat.step_stop = step_ff && (target_ff == '0);
   assign stat.div_done  = div_done;

   // one level toward the target, then clamp
   always_comb begin
      tgt_x = CMP_W'(target_ff);
      lvl_x = CMP_W'(level_ff);
      if (tgt_x > lvl_x) begin
         lvl_in = lvl_x + 1'b1;
      end else if (tgt_x < lvl_x) begin
         lvl_in = lvl_x - 1'b1;
      end else begin
         lvl_in = lvl_x;
      end
      if (lvl_in > CMP_W'(LEVEL_COUNT - 1)) begin
         lvl_in = CMP_W'(LEVEL_COUNT - 1);
      end
   end

   // with centering on and a sense past its limit, the larger signed error drives both sides, ties go to the right side
   always_comb begin
      err_l_raw = $signed({1'b0, lsen_ff}) - $signed({1'b0, left_ref_ff});
      err_r_raw = $signed({1'b0, rsen_ff}) - $signed({1'b0, right_ref_ff});
      wall      = (lsen_ff > left_limit_ff) || (rsen_ff > right_limit_ff);
      err_l_in  = '0;
      err_r_in  = '0;
      if (center_en_ff && wall) begin
         if (err_l_raw > err_r_raw) begin
            err_l_in = err_l_raw;
            err_r_in = -err_l_raw;
         end else begin
            err_l_in = -err_r_raw;
            err_r_in = err_r_raw;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff        <= '0;
         left_period_ff  <= PW'(ssrc_pkg::STOP_PERIOD);
         right_period_ff <= PW'(ssrc_pkg::STOP_PERIOD);
      end else begin
         if (cmd.stop_load) begin
            level_ff        <= '0;
            left_period_ff  <= PW'(ssrc_pkg::STOP_PERIOD);
            right_period_ff <= PW'(ssrc_pkg::STOP_PERIOD);
         end
         if (cmd.level_upd) begin
            level_ff <= LEVEL_W'(lvl_in);
         end
         if (cmd.store_left) begin
            left_period_ff <= quotient;
         end
         if (cmd.store_right) begin
            right_period_ff <= quotient;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.level_upd) begin
         err_l_ff <= err_l_in;
         err_r_ff <= err_r_in;
      end
   end

   // corrected rate, floored at one
   always_comb begin
      rate    = SUM_W'(ssrc_pkg::RATE_BASE) + (SUM_W'(level_ff) << ssrc_pkg::RATE_SHIFT);
      err_sel = cmd.div_right ? SUM_W'(err_r_ff) : SUM_W'(err_l_ff);
      sum     = rate + err_sel;
      divisor = (sum[SUM_W-1] || sum == '0) ? DIV_W'(1) : sum[DIV_W-1:0];
   end

   ssrc_div #(
      .DIVISOR_W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_left_ff  <= left_period_ff;
         out_right_ff <= right_period_ff;
         out_run_ff   <= (target_ff != '0);
         out_level_ff <= level_ff;
      end
   end

   assign rsp_left_period  = out_left_ff;
   assign rsp_right_period = out_right_ff;
   assign rsp_run_enable   = out_run_ff;
   assign rsp_level_now    = ssrc_pkg::LEVEL_OUT_W'(out_level_ff);

endmodule

>>> hdl/ssrc_ctrl.sv
// controller: sequences one tick through level update and two divisions, or a stop or idle tick straight to finish
module ssrc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output ssrc_pkg::ctrl_cmd_type  cmd,
   input  ssrc_pkg::ctrl_stat_type stat
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_RUN_L,
      ST_WAIT_L,
      ST_RUN_R,
      ST_WAIT_R,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      req_stall_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:   cmd.capture     = req_valid;
         ST_DECIDE: begin
            cmd.level_upd = stat.step_work;
            cmd.stop_load = stat.step_stop;
         end
         ST_RUN_L:  cmd.div_start   = 1'b1;
         ST_WAIT_L: cmd.store_left  = stat.div_done;
         ST_RUN_R: begin
            cmd.div_start = 1'b1;
            cmd.div_right = 1'b1;
         end
         ST_WAIT_R: cmd.store_right = stat.div_done;
         ST_FINISH: cmd.load_out    = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // result register fills from the finish state, empties on an accepted beat
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff     <= ST_DECIDE;
                  req_stall_ff <= 1'b1;
               end
            end
            ST_DECIDE: begin
               state_ff <= stat.step_work ? ST_RUN_L : ST_FINISH;
            end
            ST_RUN_L:  state_ff <= ST_WAIT_L;
            ST_WAIT_L: begin
               if (stat.div_done) begin
                  state_ff <= ST_RUN_R;
               end
            end
            ST_RUN_R:  state_ff <= ST_WAIT_R;
            ST_WAIT_R: begin
               if (stat.div_done) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  state_ff     <= ST_IDLE;
                  req_stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_stall_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/stepper_speed_ramp_with_centering.sv
// top level: stepper speed ramp with wall centering
// a tick with a step seen and a nonzero target runs from accept to result valid through
// decide, two passes of the shared 21-step divider (left, then right), and the result load;
// a tick with no step seen, or a stop, goes from decide straight to the result load;
// one tick is in flight at a time; the next beat can be taken as the result appears
// synchronous reset clears the level, sets both periods to 2500 and config to defaults
module stepper_speed_ramp_with_centering #(
   parameter int LEVEL_COUNT = ssrc_pkg::LEVEL_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ssrc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ssrc_pkg::CSR_DATA_W-1:0]  csr_data,
   // tick input channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ssrc_pkg::TARGET_W-1:0]    req_target_level,
   input  logic                             req_step_seen,
   input  logic [ssrc_pkg::SENSE_W-1:0]     req_left_sense,
   input  logic [ssrc_pkg::SENSE_W-1:0]     req_right_sense,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ssrc_pkg::PERIOD_W-1:0]    rsp_left_period,
   output logic [ssrc_pkg::PERIOD_W-1:0]    rsp_right_period,
   output logic                             rsp_run_enable,
   output logic [ssrc_pkg::LEVEL_OUT_W-1:0] rsp_level_now
);

   ssrc_pkg::ctrl_cmd_type  cmd;
   ssrc_pkg::ctrl_stat_type stat;
   logic                    csr_wr;

   // config registers take a write every cycle; user writes only while idle, not enforced
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   // state machine: handshakes and the order of datapath operations
   ssrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // level ramp, centering correction, period divider and result beat register
   ssrc_datapath #(
      .LEVEL_COUNT (LEVEL_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_wr           (csr_wr),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_target_level (req_target_level),
      .req_step_seen    (req_step_seen),
      .req_left_sense   (req_left_sense),
      .req_right_sense  (req_right_sense),
      .rsp_left_period  (rsp_left_period),
      .rsp_right_period (rsp_right_period),
      .rsp_run_enable   (rsp_run_enable),
      .rsp_level_now    (rsp_level_now)
   );

endmodule

>>> hdl/ssrc_checker.sv
// port-level checker for the speed ramp block, bound to the top level
module ssrc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [ssrc_pkg::PERIOD_W-1:0]    rsp_left_period,
   input logic [ssrc_pkg::PERIOD_W-1:0]    rsp_right_period,
   input logic                             rsp_run_enable,
   input logic [ssrc_pkg::LEVEL_OUT_W-1:0] rsp_level_now
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_period) &&
      $stable(rsp_right_period) && $stable(rsp_run_enable) && $stable(rsp_level_now))
      else $error("result beat changed while stalled");

   // one tick at a time: an accepted beat closes the input
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open right after an accepted beat");

   // a new result only comes out of a tick in flight
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result beat without a tick in flight");

   // periods never collapse to zero
   a_period_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_left_period != '0 && rsp_right_period != '0)
      else $error("zero step period on result");

endmodule

bind stepper_speed_ramp_with_centering ssrc_checker u_ssrc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_left_period  (rsp_left_period),
   .rsp_right_period (rsp_right_period),
   .rsp_run_enable   (rsp_run_enable),
   .rsp_level_now    (rsp_level_now)
);
